// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared sizes, codes and beat types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS  = 8;
	localparam int MAX_ENTRIES = 16;
	localparam int SIZE_BITS   = 16;

	localparam int TAG_W       = 16;
	localparam int FIELD_W     = 16;
	localparam int BIDX_OUT_W  = 3;
	localparam int BLK_IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int BLK_CNT_W   = $clog2(MAX_BLOCKS + 1);
	localparam int ENT_IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int ENT_CNT_W   = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RELEASE = 2'd2
	} ffba_op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOFIT    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} ffba_status_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [FIELD_W-1:0] amount;
		logic [TAG_W-1:0]   release_tag;
	} ffba_req_t;

	typedef struct packed {
		ffba_status_t          status;
		logic [TAG_W-1:0]      alloc_tag;
		logic [BIDX_OUT_W-1:0] block_index;
		logic [FIELD_W-1:0]    size_moved;
	} ffba_rsp_t;

	typedef struct packed {
		logic                 valid;
		logic [TAG_W-1:0]     tag;
		logic [BLK_IDX_W-1:0] blk;
		logic [SIZE_BITS-1:0] size;
	} ffba_entry_t;

	typedef struct packed {
		logic load;
		logic sub;
		logic add;
	} ffba_blk_cmd_t;

	function automatic logic [SIZE_BITS-1:0] to_size(input logic [FIELD_W-1:0] a);
		logic [SIZE_BITS+FIELD_W-1:0] ext;
		ext = {{SIZE_BITS{1'b0}}, a};
		return ext[SIZE_BITS-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] from_size(input logic [SIZE_BITS-1:0] s);
		logic [SIZE_BITS+FIELD_W-1:0] ext;
		ext = {{FIELD_W{1'b0}}, s};
		return ext[FIELD_W-1:0];
	endfunction

	function automatic logic [BIDX_OUT_W-1:0] to_bidx(input logic [BLK_IDX_W-1:0] b);
		logic [BLK_IDX_W+BIDX_OUT_W-1:0] ext;
		ext = {{BIDX_OUT_W{1'b0}}, b};
		return ext[BIDX_OUT_W-1:0];
	endfunction

endpackage

// ----- rtl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a row of block cells and a row of entry cells.
// ----------------------------------------------------------------------------
// The block handles one request beat at a time. An add beat writes its
// result straight into the pending result register. An allocate beat sends a
// search token down the row of block cells, one cell per clock, and stops at
// the first cell whose remaining capacity covers the request. A release beat
// sends a token down the row of entry cells the same way. The request side
// stalls from acceptance until the response is latched into the output
// register, and a finished response may wait there while the next request is
// already being taken. Live entries stay packed at the low cells in order of
// creation, so the first match the token meets is the oldest entry with that
// tag; releasing it slides every cell above it down by one in the same clock.
// Operation code 3 is swallowed with no response.
// ----------------------------------------------------------------------------
module first_fit_block_allocator import ffba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  ffba_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ffba_rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_BSCAN,
		S_ESCAN,
		S_RESP
	} state_t;

	state_t state_q;

	logic [BLK_CNT_W-1:0] blk_cnt_q;
	logic [ENT_CNT_W-1:0] ent_cnt_q;
	logic [TAG_W-1:0]     next_tag_q;
	logic [SIZE_BITS-1:0] amt_q;
	logic [TAG_W-1:0]     rtag_q;
	ffba_rsp_t            res_q;
	ffba_rsp_t            rsp_q;
	logic                 rsp_valid_q;

	logic                 req_acc;
	logic [SIZE_BITS-1:0] amt_in;
	logic                 rsp_load;

	// block row
	logic [MAX_BLOCKS:0]   blk_tok;
	logic [MAX_BLOCKS-1:0] blk_pass;
	logic [MAX_BLOCKS-1:0] blk_hit;
	logic [MAX_BLOCKS-1:0] blk_live;
	ffba_blk_cmd_t         blk_cmd [MAX_BLOCKS];
	logic [SIZE_BITS-1:0]  blk_val;
	logic                  blk_any;
	logic [BLK_IDX_W-1:0]  blk_hit_idx;

	// entry row
	logic [MAX_ENTRIES:0]   ent_tok;
	logic [MAX_ENTRIES-1:0] ent_pass;
	logic [MAX_ENTRIES-1:0] ent_hit;
	logic [MAX_ENTRIES-1:0] ent_wr;
	logic [MAX_ENTRIES-1:0] ent_shift;
	ffba_entry_t            ent_out [MAX_ENTRIES];
	ffba_entry_t            ent_up  [MAX_ENTRIES];
	ffba_entry_t            ent_new;
	ffba_entry_t            ent_sel;
	logic                   ent_any;
	logic [ENT_IDX_W-1:0]   ent_hit_idx;
	logic                   ent_full;

	logic add_commit;
	logic alloc_commit;
	logic rel_commit;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign amt_in    = to_size(req.amount);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// move the pending result into the output register once that is free
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);

	assign ent_full = (ent_cnt_q == ENT_CNT_W'(MAX_ENTRIES));

	// inject tokens at the head of each row on acceptance
	assign blk_tok[0] = req_acc && (req.operation == OP_ALLOC);
	assign ent_tok[0] = req_acc && (req.operation == OP_RELEASE);

	// commits: each one touches exactly the cells it names
	assign add_commit   = req_acc && (req.operation == OP_ADD) &&
	                      (blk_cnt_q < BLK_CNT_W'(MAX_BLOCKS));
	assign alloc_commit = (state_q == S_BSCAN) && blk_any && !ent_full;
	assign rel_commit   = (state_q == S_ESCAN) && ent_any;

	// encode the one-hot hit of each row
	always_comb begin
		blk_hit_idx = '0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			if (blk_hit[i]) begin
				blk_hit_idx = blk_hit_idx | BLK_IDX_W'(i);
			end
		end
	end

	always_comb begin
		ent_hit_idx = '0;
		ent_sel     = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (ent_hit[i]) begin
				ent_hit_idx = ent_hit_idx | ENT_IDX_W'(i);
				ent_sel     = ffba_entry_t'(ent_sel | ent_out[i]);
			end
		end
	end

	assign blk_any = |blk_hit;
	assign ent_any = |ent_hit;

	// one value bus serves load, subtract and give-back; one commit per clock
	always_comb begin
		if (add_commit) begin
			blk_val = amt_in;
		end else if (alloc_commit) begin
			blk_val = amt_q;
		end else begin
			blk_val = ent_sel.size;
		end
	end

	assign ent_new = '{valid: 1'b1, tag: next_tag_q, blk: blk_hit_idx, size: amt_q};

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_blk
		assign blk_live[g]     = (BLK_CNT_W'(g) < blk_cnt_q);
		assign blk_cmd[g].load = add_commit && (blk_cnt_q == BLK_CNT_W'(g));
		assign blk_cmd[g].sub  = alloc_commit && blk_hit[g];
		assign blk_cmd[g].add  = rel_commit && (ent_sel.blk == BLK_IDX_W'(g));

		ffba_blk_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (blk_cmd[g]),
			.value    (blk_val),
			.request  (amt_q),
			.live     (blk_live[g]),
			.token_in (blk_tok[g]),
			.pass     (blk_pass[g]),
			.hit      (blk_hit[g])
		);

		assign blk_tok[g+1] = blk_pass[g];
	end

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_ent
		assign ent_wr[g]    = alloc_commit && (ent_cnt_q == ENT_CNT_W'(g));
		assign ent_shift[g] = rel_commit && (ENT_IDX_W'(g) >= ent_hit_idx);

		if (g == MAX_ENTRIES - 1) begin : g_top
			assign ent_up[g] = '0;
		end else begin : g_mid
			assign ent_up[g] = ent_out[g+1];
		end

		ffba_ent_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr       (ent_wr[g]),
			.wr_data  (ent_new),
			.shift    (ent_shift[g]),
			.up       (ent_up[g]),
			.key      (rtag_q),
			.token_in (ent_tok[g]),
			.ent      (ent_out[g]),
			.pass     (ent_pass[g]),
			.hit      (ent_hit[g])
		);

		assign ent_tok[g+1] = ent_pass[g];
	end

	// sequencer: counters, pending result and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			blk_cnt_q   <= '0;
			ent_cnt_q   <= '0;
			next_tag_q  <= '0;
			amt_q       <= '0;
			rtag_q      <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// load a new response, or drop the old one once it has been taken
			if (rsp_load) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						case (req.operation)
							OP_ADD: begin
								if (add_commit) begin
									blk_cnt_q <= blk_cnt_q + 1'b1;
									res_q <= '{status: ST_OK, alloc_tag: '0,
									           block_index: to_bidx(blk_cnt_q[BLK_IDX_W-1:0]),
									           size_moved: from_size(amt_in)};
								end else begin
									res_q <= '{status: ST_FULL, alloc_tag: '0,
									           block_index: '0, size_moved: '0};
								end
								state_q <= S_RESP;
							end
							OP_ALLOC: begin
								amt_q   <= amt_in;
								state_q <= S_BSCAN;
							end
							OP_RELEASE: begin
								rtag_q  <= req.release_tag;
								state_q <= S_ESCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_BSCAN: begin
					if (blk_any) begin
						if (ent_full) begin
							res_q <= '{status: ST_FULL, alloc_tag: '0,
							           block_index: '0, size_moved: '0};
						end else begin
							ent_cnt_q  <= ent_cnt_q + 1'b1;
							next_tag_q <= next_tag_q + 1'b1;
							res_q <= '{status: ST_OK, alloc_tag: next_tag_q,
							           block_index: to_bidx(blk_hit_idx),
							           size_moved: from_size(amt_q)};
						end
						state_q <= S_RESP;
					end else if (blk_tok[MAX_BLOCKS]) begin
						res_q <= '{status: ST_NOFIT, alloc_tag: '0,
						           block_index: '0, size_moved: '0};
						state_q <= S_RESP;
					end
				end

				S_ESCAN: begin
					if (ent_any) begin
						ent_cnt_q <= ent_cnt_q - 1'b1;
						res_q <= '{status: ST_OK, alloc_tag: rtag_q,
						           block_index: to_bidx(ent_sel.blk),
						           size_moved: from_size(ent_sel.size)};
						state_q <= S_RESP;
					end else if (ent_tok[MAX_ENTRIES]) begin
						res_q <= '{status: ST_NOTFOUND, alloc_tag: rtag_q,
						           block_index: '0, size_moved: '0};
						state_q <= S_RESP;
					end
				end

				S_RESP: begin
					// hold the result until the output register is free
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/ffba_blk_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_blk_cell
// One block slot: remaining capacity and a search token stage.
// ----------------------------------------------------------------------------
module ffba_blk_cell import ffba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffba_blk_cmd_t        cmd,
	input  logic [SIZE_BITS-1:0] value,
	input  logic [SIZE_BITS-1:0] request,
	input  logic                 live,
	input  logic                 token_in,
	output logic                 pass,
	output logic                 hit
);

	logic [SIZE_BITS-1:0] rem_q;
	logic                 token_q;
	logic                 fits;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= value;
		end else if (cmd.sub) begin
			rem_q <= rem_q - value;
		end else if (cmd.add) begin
			rem_q <= rem_q + value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
		end else begin
			token_q <= token_in;
		end
	end

	assign fits = live && (request <= rem_q);
	assign hit  = token_q && fits;
	assign pass = token_q && !fits;

endmodule

// ----- rtl/ffba_ent_cell.sv -----
// ----------------------------------------------------------------------------
// ffba_ent_cell
// One allocation slot: entry fields, tag match and a search token stage.
// ----------------------------------------------------------------------------
module ffba_ent_cell import ffba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  ffba_entry_t      wr_data,
	input  logic             shift,
	input  ffba_entry_t      up,
	input  logic [TAG_W-1:0] key,
	input  logic             token_in,
	output ffba_entry_t      ent,
	output logic             pass,
	output logic             hit
);

	logic                 valid_q;
	logic [TAG_W-1:0]     tag_q;
	logic [BLK_IDX_W-1:0] blk_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 token_q;
	logic                 match;

	// close the gap left by a released entry: take the upper neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			token_q <= 1'b0;
		end else begin
			token_q <= token_in;
			if (shift) begin
				valid_q <= up.valid;
			end else if (wr) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q  <= up.tag;
			blk_q  <= up.blk;
			size_q <= up.size;
		end else if (wr) begin
			tag_q  <= wr_data.tag;
			blk_q  <= wr_data.blk;
			size_q <= wr_data.size;
		end
	end

	assign match = valid_q && (tag_q == key);
	assign hit   = token_q && match;
	assign pass  = token_q && !match;
	assign ent   = '{valid: valid_q, tag: tag_q, blk: blk_q, size: size_q};

endmodule
